// ===== rtl/rag_pkg.sv =====
// Shared types, constants and helpers for the region allocation / GC accounting block.
package rag_pkg;

    localparam int ID_BITS   = 16;
    localparam int SIZE_BITS = 32;

    // beat field widths
    localparam int CMD_W  = 1;
    localparam int ID_W   = 16;
    localparam int SIZE_W = 32;
    localparam int TIME_W = 32;
    localparam int CFG_W  = 32;
    localparam int OUT_W32 = 32;

    // slave tdata layout
    localparam int IN_ID_LSB   = 0;
    localparam int IN_SIZE_LSB = IN_ID_LSB + ID_W;
    localparam int IN_TIME_LSB = IN_SIZE_LSB + SIZE_W;
    localparam int IN_BITS     = IN_TIME_LSB + TIME_W;
    localparam int IN_W        = ((IN_BITS + 7) / 8) * 8;

    // master tdata layout: 4 flags plus 6 words of 32 bits
    localparam int OUT_BITS = 4 + 6 * OUT_W32;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CFG_W-1:0] REGION_SIZE_RST = 32'd1048576;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_DEAD  = 1'b1;

    typedef struct packed {
        logic garb;
        logic rg;
        logic mgr;
    } t_flags;

    typedef enum logic [2:0] {
        ACC_NONE  = 3'd0,
        ACC_START = 3'd1,
        ACC_PLACE = 3'd2,
        ACC_GC    = 3'd3,
        ACC_DEAD  = 3'd4,
        ACC_PEAK  = 3'd5
    } t_acc_op;

    typedef struct packed {
        t_acc_op               op;
        logic [SIZE_BITS-1:0]  size;
        logic [TIME_W-1:0]     tm;
        logic                  to_garb;
    } t_acct_cmd;

    typedef struct packed {
        logic                  fits;
        logic                  under;
        logic [SIZE_BITS-1:0]  coll;
        logic [TIME_W-1:0]     gct;
        logic [SIZE_BITS-1:0]  live;
        logic [SIZE_BITS-1:0]  peak_next;
        logic [SIZE_BITS-1:0]  free;
        logic [SIZE_BITS-1:0]  garb;
    } t_acct_stat;

    function automatic logic [SIZE_BITS-1:0] sat_add(input logic [SIZE_BITS-1:0] a,
                                                     input logic [SIZE_BITS-1:0] b);
        logic [SIZE_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SIZE_BITS] ? {SIZE_BITS{1'b1}} : s[SIZE_BITS-1:0];
    endfunction

endpackage

// ===== rtl/region_alloc_gc_accounting.sv =====
// Top level: single-region allocator and GC bookkeeping sequencer.
//
// Channels:
//   s_axis: one command beat. tuser = command (0 allocate, 1 make dead),
//           tdata = object id, object size, allocation time.
//   m_axis: one result beat per command, held in an output register.
//   cfg:    i_cfg_valid/o_cfg_ready/i_cfg_data write the region size and
//           reload the free byte count. Always ready.
// Timing: a command is accepted in IDLE and its flag entry is read from the
//   flag memory; EXE updates it, or, when the object does not fit, runs a
//   collection and RETRY makes a second placement attempt; FIN then writes
//   the entry back as the result is loaded. A new command is taken only once
//   FIN has returned to IDLE, so commands do not overlap. The flag memory
//   read/modify/write is the loop that sets this pacing.
// Reset: counters take their reset values and a sweep clears all 65536 flag
//   entries, one per cycle; s_axis_tready stays low until the sweep ends.
// Stall: while m_axis_tready is low the result register holds; the next
//   command is still accepted and parks in its final step until the
//   register frees.
module region_alloc_gc_accounting (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [15:0] object_id, [47:16] object_size, [79:48] alloc_time
    input  logic [rag_pkg::IN_W-1:0]        s_axis_tdata,
    // [0] command
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] success, [1] was_duplicate, [2] gc_done, [34:3] collected_bytes,
    // [66:35] gc_time, [67] live_underflow, [99:68] live_bytes,
    // [131:100] peak_live, [163:132] free_now, [195:164] pending_garbage
    output logic [rag_pkg::OUT_W-1:0]       m_axis_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rag_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int SB = rag_pkg::SIZE_BITS;
    localparam int IB = rag_pkg::ID_BITS;
    localparam int W32 = rag_pkg::OUT_W32;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EXE   = 4'b0010,
        ST_RETRY = 4'b0100,
        ST_FIN   = 4'b1000
    } t_state;

    t_state                         r_state, n_state;
    logic                           r_cmd;
    logic [IB-1:0]                  r_id;
    logic [SB-1:0]                  r_size;
    logic [rag_pkg::TIME_W-1:0]     r_time;
    rag_pkg::t_flags                r_flags, n_flags;
    logic                           r_ok, n_ok;
    logic                           r_dup, n_dup;
    logic                           r_gc, n_gc;
    logic                           r_out_valid, n_out_valid;
    logic [rag_pkg::OUT_W-1:0]      r_out_data, n_out_data;

    logic                           w_in_acc;
    logic                           w_clr_busy;
    logic                           w_load;
    logic                           w_wr_en;
    rag_pkg::t_flags                w_rd_flags;
    rag_pkg::t_acct_cmd             w_acmd;
    rag_pkg::t_acct_stat            w_astat;

    assign s_axis_tready = (r_state == ST_IDLE) && !w_clr_busy;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    rag_flag_mem u_flags (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_in_acc),
        .i_rd_addr  (IB'(s_axis_tdata[rag_pkg::IN_ID_LSB +: rag_pkg::ID_W])),
        .o_rd_data  (w_rd_flags),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (r_id),
        .i_wr_data  (r_flags),
        .o_clr_busy (w_clr_busy)
    );

    rag_acct u_acct (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_acmd),
        .o_stat     (w_astat)
    );

    always_comb begin
        n_state      = r_state;
        n_flags      = r_flags;
        n_ok         = r_ok;
        n_dup        = r_dup;
        n_gc         = r_gc;
        w_load       = 1'b0;
        w_wr_en      = 1'b0;
        w_acmd.op      = rag_pkg::ACC_NONE;
        w_acmd.size    = r_size;
        w_acmd.tm      = r_time;
        w_acmd.to_garb = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    w_acmd.op = rag_pkg::ACC_START;
                    n_ok      = 1'b0;
                    n_dup     = 1'b0;
                    n_gc      = 1'b0;
                    n_state   = ST_EXE;
                end
            end
            ST_EXE: begin
                n_flags = w_rd_flags;
                if (r_cmd == rag_pkg::CMD_ALLOC) begin
                    if (w_rd_flags.mgr) begin
                        n_ok    = 1'b1;
                        n_dup   = 1'b1;
                        n_state = ST_FIN;
                    end else if (w_astat.fits) begin
                        w_acmd.op   = rag_pkg::ACC_PLACE;
                        n_ok        = 1'b1;
                        n_flags.rg  = 1'b1;
                        n_flags.mgr = 1'b1;
                        n_state     = ST_FIN;
                    end else begin
                        w_acmd.op = rag_pkg::ACC_GC;
                        n_gc      = 1'b1;
                        n_state   = ST_RETRY;
                    end
                end else begin
                    w_acmd.op      = rag_pkg::ACC_DEAD;
                    w_acmd.to_garb = w_rd_flags.rg && !w_rd_flags.garb;
                    n_ok           = w_rd_flags.rg && !w_rd_flags.garb;
                    if (w_rd_flags.rg) begin
                        n_flags.garb = 1'b1;
                        n_flags.rg   = 1'b0;
                    end
                    n_state = ST_FIN;
                end
            end
            ST_RETRY: begin
                if (w_astat.fits) begin
                    w_acmd.op   = rag_pkg::ACC_PLACE;
                    n_ok        = 1'b1;
                    n_flags.rg  = 1'b1;
                    n_flags.mgr = 1'b1;
                end
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_acmd.op = rag_pkg::ACC_PEAK;
                    w_load    = 1'b1;
                    w_wr_en   = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_data = {
            (rag_pkg::OUT_W - rag_pkg::OUT_BITS)'(0),
            W32'(w_astat.garb),
            W32'(w_astat.free),
            W32'(w_astat.peak_next),
            W32'(w_astat.live),
            w_astat.under,
            W32'(w_astat.gct),
            W32'(w_astat.coll),
            r_gc,
            r_dup,
            r_ok
        };
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd  <= s_axis_tuser;
            r_id   <= IB'(s_axis_tdata[rag_pkg::IN_ID_LSB +: rag_pkg::ID_W]);
            r_size <= SB'(s_axis_tdata[rag_pkg::IN_SIZE_LSB +: rag_pkg::SIZE_W]);
            r_time <= s_axis_tdata[rag_pkg::IN_TIME_LSB +: rag_pkg::TIME_W];
        end
        if (w_load) begin
            r_out_data <= n_out_data;
        end
        r_flags <= n_flags;
        r_ok    <= n_ok;
        r_dup   <= n_dup;
        r_gc    <= n_gc;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef ASSERT_OFF
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clr_busy |-> !s_axis_tready)
        else $error("command accepted during flag clear");
`endif

`ifndef ASSERT_OFF
    a_accept_to_exe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_EXE))
        else $error("accepted command did not start");
`endif

`ifndef ASSERT_OFF
    a_dup_no_gc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_dup) |-> (r_ok && !r_gc && r_cmd == rag_pkg::CMD_ALLOC))
        else $error("duplicate result inconsistent");
`endif

endmodule

// ===== rtl/rag_flag_mem.sv =====
// Per-object flag memory with a clearing sweep after reset.
module rag_flag_mem (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_rd_en,
    input  logic [rag_pkg::ID_BITS-1:0]     i_rd_addr,
    output rag_pkg::t_flags                 o_rd_data,
    input  logic                            i_wr_en,
    input  logic [rag_pkg::ID_BITS-1:0]     i_wr_addr,
    input  rag_pkg::t_flags                 i_wr_data,
    output logic                            o_clr_busy
);

    localparam int DEPTH = 1 << rag_pkg::ID_BITS;

    rag_pkg::t_flags                 r_mem [DEPTH];
    rag_pkg::t_flags                 r_rd_data;
    logic                            r_clr_busy;
    logic [rag_pkg::ID_BITS-1:0]     r_clr_addr;

    logic                            w_we;
    logic [rag_pkg::ID_BITS-1:0]     w_waddr;
    rag_pkg::t_flags                 w_wdata;

    always_comb begin
        w_we    = r_clr_busy | i_wr_en;
        w_waddr = r_clr_busy ? r_clr_addr : i_wr_addr;
        w_wdata = r_clr_busy ? rag_pkg::t_flags'('0) : i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {rag_pkg::ID_BITS{1'b1}}) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clr_busy = r_clr_busy;

`ifndef ASSERT_OFF
    a_no_rd_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !i_rd_en)
        else $error("flag read during clear sweep");
`endif

endmodule

// ===== rtl/rag_acct.sv =====
// Byte counters: free, garbage, manager live, peak, and per-beat collection results.
module rag_acct (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rag_pkg::CFG_W-1:0]           i_cfg_data,
    input  rag_pkg::t_acct_cmd                  i_cmd,
    output rag_pkg::t_acct_stat                 o_stat
);

    localparam int SB = rag_pkg::SIZE_BITS;

    logic [SB-1:0]              r_free, n_free;
    logic [SB-1:0]              r_lim, n_lim;
    logic [SB-1:0]              r_garb, n_garb;
    logic [SB-1:0]              r_live, n_live;
    logic [SB-1:0]              r_peak, n_peak;
    logic [SB-1:0]              r_coll, n_coll;
    logic [rag_pkg::TIME_W-1:0] r_gct, n_gct;
    logic                       r_under, n_under;

    logic [SB-1:0]              w_gc_sum;
    logic [SB-1:0]              w_gc_free;
    logic                       w_under;
    logic [SB-1:0]              w_peak_next;

    always_comb begin
        w_gc_sum    = rag_pkg::sat_add(r_free, r_garb);
        w_gc_free   = (w_gc_sum > r_lim) ? r_lim : w_gc_sum;
        w_under     = i_cmd.size > r_live;
        w_peak_next = (r_live > r_peak) ? r_live : r_peak;

        n_free  = r_free;
        n_lim   = r_lim;
        n_garb  = r_garb;
        n_live  = r_live;
        n_peak  = r_peak;
        n_coll  = r_coll;
        n_gct   = r_gct;
        n_under = r_under;

        case (i_cmd.op)
            rag_pkg::ACC_START: begin
                n_coll  = '0;
                n_gct   = '0;
                n_under = 1'b0;
            end
            rag_pkg::ACC_PLACE: begin
                n_free = r_free - i_cmd.size;
                n_live = rag_pkg::sat_add(r_live, i_cmd.size);
            end
            rag_pkg::ACC_GC: begin
                n_coll = r_garb;
                n_garb = '0;
                n_gct  = i_cmd.tm;
                n_free = w_gc_free;
            end
            rag_pkg::ACC_DEAD: begin
                n_under = w_under;
                n_live  = w_under ? '0 : r_live - i_cmd.size;
                if (i_cmd.to_garb) begin
                    n_garb = rag_pkg::sat_add(r_garb, i_cmd.size);
                end
            end
            rag_pkg::ACC_PEAK: begin
                n_peak = w_peak_next;
            end
            default: begin
            end
        endcase

        // a region size write reloads free bytes
        if (i_cfg_we) begin
            n_lim  = SB'(i_cfg_data);
            n_free = SB'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= SB'(rag_pkg::REGION_SIZE_RST);
            r_lim  <= SB'(rag_pkg::REGION_SIZE_RST);
            r_garb <= '0;
            r_live <= '0;
            r_peak <= '0;
        end else begin
            r_free <= n_free;
            r_lim  <= n_lim;
            r_garb <= n_garb;
            r_live <= n_live;
            r_peak <= n_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        r_coll  <= n_coll;
        r_gct   <= n_gct;
        r_under <= n_under;
    end

    always_comb begin
        o_stat.fits      = i_cmd.size <= r_free;
        o_stat.under     = r_under;
        o_stat.coll      = r_coll;
        o_stat.gct       = r_gct;
        o_stat.live      = r_live;
        o_stat.peak_next = w_peak_next;
        o_stat.free      = r_free;
        o_stat.garb      = r_garb;
    end

`ifndef ASSERT_OFF
    a_free_le_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= r_lim)
        else $error("free bytes above region size");
`endif

`ifndef ASSERT_OFF
    a_gc_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == rag_pkg::ACC_GC && !i_cfg_we) |=> (r_garb == '0 && r_coll == $past(r_garb)))
        else $error("collection did not return all garbage");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the region allocation and GC accounting block.
`timescale 1ns / 100ps

module tb_top;
    import rag_pkg::*;

    localparam int WATCHDOG_LIMIT = 300000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_PRINTS     = 40;

    typedef logic [SIZE_BITS-1:0] t_bytes;

    // same bit order as m_axis_tdata, success in bit 0
    typedef struct packed {
        logic [SIZE_W-1:0] garb;
        logic [SIZE_W-1:0] free;
        logic [SIZE_W-1:0] peak;
        logic [SIZE_W-1:0] live;
        logic              under;
        logic [TIME_W-1:0] gct;
        logic [SIZE_W-1:0] coll;
        logic              gc;
        logic              dup;
        logic              ok;
    } t_acct_result;

    typedef struct {
        logic [ID_W-1:0] id;
        t_bytes          size;
    } t_obj;

    class gc_ledger;
        t_flags       flags [0:(1<<ID_BITS)-1];
        t_bytes       region_sz, free_b, used_b, reg_live, garb_b, mgr_live, peak_live;
        logic [31:0]  gc_cnt;
        t_acct_result owed [$];
        int errors, checked, n_alloc, n_dead, n_gc, n_dup, n_under, n_cfg;

        function new();
            foreach (flags[i]) flags[i] = '0;
            region_sz = REGION_SIZE_RST;
            free_b    = REGION_SIZE_RST;
            used_b    = '0;
            reg_live  = '0;
            garb_b    = '0;
            mgr_live  = '0;
            peak_live = '0;
            gc_cnt    = '0;
            errors = 0; checked = 0; n_alloc = 0; n_dead = 0;
            n_gc = 0; n_dup = 0; n_under = 0; n_cfg = 0;
        endfunction

        function t_bytes add_clamp(t_bytes a, t_bytes b);
            t_bytes s;
            s = a + b;
            return (s < a) ? '1 : s;
        endfunction

        // a size write reloads the free count, everything else is kept
        function void set_region(t_bytes v);
            region_sz = v;
            free_b    = v;
            n_cfg++;
        endfunction

        function bit place(logic [ID_W-1:0] idx, t_bytes size);
            if (size > free_b) return 1'b0;
            flags[idx].rg = 1'b1;
            free_b   -= size;
            used_b    = add_clamp(used_b, size);
            reg_live  = add_clamp(reg_live, size);
            return 1'b1;
        endfunction

        function void note_command(logic cmd, logic [ID_W-1:0] id, t_bytes size,
                                   logic [TIME_W-1:0] tm);
            t_acct_result r;
            bit           done;
            r = '0;
            if (cmd == CMD_ALLOC) begin
                n_alloc++;
                if (flags[id].mgr) begin
                    r.ok  = 1'b1;
                    r.dup = 1'b1;
                    n_dup++;
                end else begin
                    done = place(id, size);
                    if (!done) begin
                        // no room: collect all garbage, then retry once
                        r.coll = garb_b;
                        garb_b = '0;
                        free_b = add_clamp(free_b, r.coll);
                        if (free_b > region_sz) free_b = region_sz;
                        r.gc   = 1'b1;
                        r.gct  = tm;
                        gc_cnt++;
                        n_gc++;
                        done = place(id, size);
                    end
                    if (done) begin
                        r.ok     = 1'b1;
                        mgr_live = add_clamp(mgr_live, size);
                        flags[id].mgr = 1'b1;
                        if (peak_live < mgr_live) peak_live = mgr_live;
                    end
                end
            end else begin
                n_dead++;
                if (size > mgr_live) begin
                    mgr_live = '0;
                    r.under  = 1'b1;
                    n_under++;
                end else begin
                    mgr_live -= size;
                end
                if (flags[id].rg) begin
                    if (!flags[id].garb) begin
                        reg_live = (size > reg_live) ? '0 : reg_live - size;
                        garb_b   = add_clamp(garb_b, size);
                        flags[id].garb = 1'b1;
                        r.ok = 1'b1;
                    end
                    flags[id].rg = 1'b0;
                end
            end
            r.live = mgr_live;
            r.peak = peak_live;
            r.free = free_b;
            r.garb = garb_b;
            owed.insert(owed.size(), r);
        endfunction

        task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
            if (errors < MAX_PRINTS)
                $display("[%0t] result %0d: %s got 0x%08h expected 0x%08h",
                         $time, checked, field, got, want);
            errors++;
        endtask

        task check_result(t_acct_result got);
            t_acct_result want;
            if (owed.size() == 0) begin
                report_mismatch("result with nothing owed", got.live, 0);
                return;
            end
            want = owed.pop_front();
            if (got.ok !== want.ok)       report_mismatch("success", got.ok, want.ok);
            if (got.dup !== want.dup)     report_mismatch("was_duplicate", got.dup, want.dup);
            if (got.gc !== want.gc)       report_mismatch("gc_done", got.gc, want.gc);
            if (got.coll !== want.coll)   report_mismatch("collected_bytes", got.coll, want.coll);
            if (got.gct !== want.gct)     report_mismatch("gc_time", got.gct, want.gct);
            if (got.under !== want.under) report_mismatch("live_underflow", got.under, want.under);
            if (got.live !== want.live)   report_mismatch("live_bytes", got.live, want.live);
            if (got.peak !== want.peak)   report_mismatch("peak_live", got.peak, want.peak);
            if (got.free !== want.free)   report_mismatch("free_now", got.free, want.free);
            if (got.garb !== want.garb)   report_mismatch("pending_garbage", got.garb, want.garb);
            checked++;
        endtask

        function int owed_count();
            return owed.size();
        endfunction
    endclass

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic [IN_W-1:0]   s_axis_tdata  = '0;
    logic              s_axis_tuser  = 1'b0;
    logic              m_axis_tready = 1'b0;
    logic              i_cfg_valid   = 1'b0;
    logic [CFG_W-1:0]  i_cfg_data    = '0;
    logic              s_axis_tready;
    logic              m_axis_tvalid;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              o_cfg_ready;

    gc_ledger    ledger;
    t_obj        born [$];
    t_bytes      cur_region = REGION_SIZE_RST;
    int unsigned stamp;
    bit          quiet      = 1'b0;
    int          hold_asks  = 0;
    int          holds_done = 0;
    int          hold_left  = 0;
    int          stall_left = 0;
    int          idle_cycles = 0;

    region_alloc_gc_accounting uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic int gap_cycles();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    function automatic t_bytes pick_size();
        int unsigned r;
        t_bytes      hi;
        r  = $urandom_range(0, 99);
        hi = (cur_region >> 3) + 1;
        if (r < 70) return $urandom_range(0, hi);
        if (r < 92) return $urandom_range(0, cur_region);
        return $urandom;
    endfunction

    // beat monitors
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                ledger.note_command(s_axis_tuser, s_axis_tdata[IN_ID_LSB +: ID_W],
                                    s_axis_tdata[IN_SIZE_LSB +: SIZE_W],
                                    s_axis_tdata[IN_TIME_LSB +: TIME_W]);
            if (m_axis_tvalid && m_axis_tready)
                ledger.check_result(m_axis_tdata[OUT_BITS-1:0]);
            if (i_cfg_valid && o_cfg_ready)
                ledger.set_region(i_cfg_data);
        end
    end

    // result sink: random stalls, plus a long hold when asked
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (holds_done != hold_asks) begin
            holds_done    <= holds_done + 1;
            hold_left     <= HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 99) < 20) begin
            m_axis_tready <= 1'b0;
            stall_left    <= gap_cycles() - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("region_alloc_gc_accounting regression: fail");
        $finish;
    end

    task automatic send_command(logic cmd, logic [ID_W-1:0] id, t_bytes size,
                                logic [TIME_W-1:0] tm);
        int gap;
        gap = (!quiet && $urandom_range(0, 99) < 30) ? gap_cycles() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= IN_W'({tm, size, id});
        @(negedge i_clk);
        while (!s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // only with every result back and the pipe drained
    task automatic write_region(t_bytes value);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (ledger.owed_count() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_region = value;
    endtask

    task automatic directed_part();
        t_bytes r0;
        r0 = REGION_SIZE_RST;
        send_command(CMD_ALLOC, 16'h0000, 32'd0,          32'h0000_0000);
        send_command(CMD_ALLOC, 16'hFFFF, 32'd1000,       32'hFFFF_FFFF);
        send_command(CMD_ALLOC, 16'h0000, 32'd5,          32'h0000_0010);  // duplicate
        send_command(CMD_ALLOC, 16'h0005, 32'hFFFF_FFFF,  32'h1234_5678);  // gc, still no room
        send_command(CMD_DEAD,  16'hFFFF, 32'd1000,       32'h0);
        send_command(CMD_DEAD,  16'hFFFF, 32'd1000,       32'h0);          // gone, underflow
        send_command(CMD_ALLOC, 16'h0007, r0,             32'hA5A5_A5A5);  // fits after gc
        send_command(CMD_DEAD,  16'h0009, 32'd0,          32'h0);          // never placed
        send_command(CMD_ALLOC, 16'h8001, 32'd1,          32'h5A5A_5A5A);  // gc with no garbage
        send_command(CMD_DEAD,  16'h0007, 32'hFFFF_FFFF,  32'h0);          // clamps, garbage sat
        send_command(CMD_ALLOC, 16'h2AAA, 32'd10,         32'h0F0F_0F0F);  // free clamps at size
        send_command(CMD_ALLOC, 16'h5555, r0 - 32'd10,    32'hF0F0_F0F0);  // exact fit
        send_command(CMD_ALLOC, 16'h5555, 32'd1,          32'h0);
        send_command(CMD_DEAD,  16'h2AAA, 32'd0,          32'h0);
        send_command(CMD_DEAD,  16'h0000, 32'd0,          32'h0);
        send_command(CMD_ALLOC, 16'h1234, 32'd0,          32'h0);          // zero size, fits with no free bytes
        send_command(CMD_DEAD,  16'h5555, 32'd5,          32'h0);
        send_command(CMD_ALLOC, 16'h0005, 32'd1,          32'h7777_7777);  // retry after failure
    endtask

    // saturate the live total and garbage with a full-size region
    task automatic saturate_counters();
        send_command(CMD_ALLOC, 16'hF0F0, 32'hFFFF_FFFF, stamp);
        write_region(32'hFFFF_FFFF);
        send_command(CMD_ALLOC, 16'h0F0F, 32'hFFFF_FFFF, stamp + 1);
        send_command(CMD_DEAD,  16'hF0F0, 32'hFFFF_FFFF, stamp + 2);
        send_command(CMD_DEAD,  16'h0F0F, 32'hFFFF_FFFF, stamp + 3);
        send_command(CMD_ALLOC, 16'h3C3C, 32'd1,         stamp + 4);
    endtask

    task automatic random_phase(int count, bit with_hold);
        t_obj             o;
        int               r;
        int               k;
        logic             cmd;
        logic [ID_W-1:0]  id;
        t_bytes           size;
        logic [TIME_W-1:0] tm;
        quiet = 1'b0;
        for (int n = 0; n < count; n++) begin
            if (with_hold && n == count / 4) hold_asks++;
            if (n == count / 2) quiet = 1'b1;
            if (n == count / 2 + 20) quiet = 1'b0;
            r = $urandom_range(0, 99);
            stamp += $urandom_range(1, 4000);
            tm = stamp;
            if (r < 50 || (r < 88 && born.size() == 0)) begin
                cmd    = CMD_ALLOC;
                id     = ID_W'($urandom_range(0, 65535));
                size   = pick_size();
                o.id   = id;
                o.size = size;
                born.insert(born.size(), o);
                if (born.size() > 48) born.delete(0);
            end else if (r < 60) begin
                k    = $urandom_range(0, born.size() - 1);
                cmd  = CMD_ALLOC;
                id   = born[k].id;
                size = pick_size();
            end else if (r < 88) begin
                // well-formed release of an earlier allocation
                k    = $urandom_range(0, born.size() - 1);
                cmd  = CMD_DEAD;
                id   = born[k].id;
                size = born[k].size;
                born.delete(k);
            end else if (r < 94) begin
                cmd  = CMD_DEAD;
                id   = ID_W'($urandom_range(0, 65535));
                size = pick_size();
            end else begin
                cmd  = 1'($urandom_range(0, 1));
                id   = ID_W'($urandom_range(0, 65535));
                size = $urandom;
                tm   = $urandom;
            end
            send_command(cmd, id, size, tm);
        end
    endtask

    initial begin
        ledger = new();
        stamp  = $urandom;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_part();
        write_region(32'd1);
        random_phase(90, 1'b0);
        write_region(32'd4096);
        random_phase(110, 1'b1);
        write_region(32'd65536);
        random_phase(110, 1'b0);
        write_region(32'hFFFF_FFFF);
        saturate_counters();
        random_phase(100, 1'b0);
        write_region($urandom_range(256, 1 << 20));
        random_phase(110, 1'b1);
        write_region(REGION_SIZE_RST);
        random_phase(110, 1'b0);

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (ledger.owed_count() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d results of %0d commands (%0d allocate, %0d make-dead), %0d size writes",
                 ledger.checked, ledger.n_alloc + ledger.n_dead, ledger.n_alloc,
                 ledger.n_dead, ledger.n_cfg);
        $display("saw %0d collections, %0d duplicates, %0d live underflows; %0d mismatches",
                 ledger.n_gc, ledger.n_dup, ledger.n_under, ledger.errors);
        if (ledger.errors == 0 && ledger.owed_count() == 0)
            $display("region_alloc_gc_accounting regression: pass");
        else
            $display("region_alloc_gc_accounting regression: fail");
        $finish;
    end

endmodule
